/* sv/gcr_tsa_pkg.sv */
// ----------------------------------------------------------------------------
// GCR track sync analyser package
// Shared constants and types for the track sync analyser.
// ----------------------------------------------------------------------------
`default_nettype none

package gcr_tsa_pkg;

  localparam int MAX_TRACK_BYTES = 16384;

  localparam int CNT_W      = $clog2(MAX_TRACK_BYTES + 1);
  localparam int FIELD_W    = 14;
  localparam int FIELD_MAX  = (1 << FIELD_W) - 1;
  localparam int SMALL_CAP_I =
    ((MAX_TRACK_BYTES - 1) > FIELD_MAX) ? FIELD_MAX : (MAX_TRACK_BYTES - 1);
  localparam int HDR_LEN    = 5;
  localparam int IDX_W      = $clog2(HDR_LEN + 1);
  localparam int MUL_W      = CNT_W + 4;

  localparam logic [7:0] SYNC_BYTE = 8'hFF;

  typedef enum logic [1:0] {
    FRS_NONE     = 2'd0,
    FRS_IN_FIRST = 2'd1,
    FRS_DONE     = 2'd2
  } first_run_t;

  typedef logic [7:0] byte_t;

endpackage

`default_nettype wire

/* sv/gcr_track_sync_analyzer_top.sv */
// ----------------------------------------------------------------------------
// GCR track sync analyser
// Counts bytes and sync runs over one track and reports on the last byte.
// ----------------------------------------------------------------------------
//  channel | dir | handshake            | payload
//  --------+-----+----------------------+----------------------------------
//  in_     | in  | in_valid / in_ready  | track_byte, last_byte
//  out_    | out | out_valid / out_ready| killer/no-sync flags, counts,
//          |     |                      | header_valid, header_byte0..4
//
//  One byte per cycle unless stalled; the last byte loads the report.
//  Track state lives in registers updated on each accepted transaction;
//  the report is held in a single output register.
//  in_ready drops only while a report is held and out_ready is low.
//  Synchronous active-low reset clears track control state and out_valid.
// ----------------------------------------------------------------------------
`default_nettype none

module gcr_track_sync_analyzer_top
  import gcr_tsa_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,

  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [7:0]         in_track_byte,
  input  wire logic               in_last_byte,

  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic                    out_killer_track,
  output logic                    out_no_sync_found,
  output logic [FIELD_W-1:0]      out_bytes_before_sync,
  output logic [FIELD_W-1:0]      out_sync_runs,
  output logic                    out_header_valid,
  output logic [7:0]              out_header_byte0,
  output logic [7:0]              out_header_byte1,
  output logic [7:0]              out_header_byte2,
  output logic [7:0]              out_header_byte3,
  output logic [7:0]              out_header_byte4
);

  localparam logic [CNT_W-1:0]   TOTAL_CAP = CNT_W'(MAX_TRACK_BYTES);
  localparam logic [FIELD_W-1:0] SMALL_CAP = FIELD_W'(SMALL_CAP_I);
  localparam logic [IDX_W-1:0]   HDR_IDX   = IDX_W'(HDR_LEN);
  localparam logic [MUL_W-1:0]   K_SYNC    = MUL_W'(10);
  localparam logic [MUL_W-1:0]   K_TOTAL   = MUL_W'(9);

  // track state
  logic [CNT_W-1:0]   total_r,   total_nxt;
  logic [CNT_W-1:0]   sync_r,    sync_nxt;
  logic [FIELD_W-1:0] lead_r,    lead_nxt;
  logic [FIELD_W-1:0] runs_r,    runs_nxt;
  logic               inrun_r,   inrun_nxt;
  first_run_t         frs_r,     frs_nxt;
  logic [IDX_W-1:0]   idx_r,     idx_nxt;
  byte_t              cap_r      [HDR_LEN];
  byte_t              cap_nxt    [HDR_LEN];
  logic               trail_r,   trail_nxt;

  // report register
  logic               ovalid_r,  ovalid_nxt;
  logic               killer_r,  killer_nxt;
  logic               nosync_r,  nosync_nxt;
  logic [FIELD_W-1:0] obefore_r, obefore_nxt;
  logic [FIELD_W-1:0] oruns_r,   oruns_nxt;
  logic               hvalid_r,  hvalid_nxt;
  byte_t              hdr_r      [HDR_LEN];
  byte_t              hdr_nxt    [HDR_LEN];

  logic               accept;
  logic               is_sync;
  logic               killer_hit;

  assign in_ready = !ovalid_r || out_ready;
  assign accept   = in_valid && in_ready;
  assign is_sync  = (in_track_byte == SYNC_BYTE);

  always_comb begin
    total_nxt = total_r;
    sync_nxt  = sync_r;
    lead_nxt  = lead_r;
    runs_nxt  = runs_r;
    inrun_nxt = inrun_r;
    frs_nxt   = frs_r;
    idx_nxt   = idx_r;
    trail_nxt = trail_r;
    for (int i = 0; i < HDR_LEN; i++) begin
      cap_nxt[i] = cap_r[i];
    end

    if (accept) begin
      total_nxt = (total_r < TOTAL_CAP) ? total_r + 1'b1 : TOTAL_CAP;
      if (is_sync) begin
        sync_nxt = (sync_r < TOTAL_CAP) ? sync_r + 1'b1 : TOTAL_CAP;
        if (!inrun_r) begin
          runs_nxt = (runs_r < SMALL_CAP) ? runs_r + 1'b1 : SMALL_CAP;
        end
        inrun_nxt = 1'b1;
        if (frs_r == FRS_NONE) begin
          frs_nxt = FRS_IN_FIRST;
        end
      end else begin
        inrun_nxt = 1'b0;
        unique case (frs_r)
          FRS_NONE:     lead_nxt = (lead_r < SMALL_CAP) ? lead_r + 1'b1 : SMALL_CAP;
          FRS_IN_FIRST: frs_nxt  = FRS_DONE;
          default:      frs_nxt  = frs_r;
        endcase
      end

      if (frs_nxt == FRS_DONE) begin
        if (idx_r < HDR_IDX) begin
          cap_nxt[idx_r] = in_track_byte;
          idx_nxt        = idx_r + 1'b1;
        end else begin
          trail_nxt = 1'b1;
        end
      end
    end
  end

  assign killer_hit = (MUL_W'(sync_nxt) * K_SYNC) > (MUL_W'(total_nxt) * K_TOTAL);

  always_comb begin
    ovalid_nxt  = ovalid_r && !out_ready;
    killer_nxt  = killer_r;
    nosync_nxt  = nosync_r;
    obefore_nxt = obefore_r;
    oruns_nxt   = oruns_r;
    hvalid_nxt  = hvalid_r;
    for (int i = 0; i < HDR_LEN; i++) begin
      hdr_nxt[i] = hdr_r[i];
    end

    if (accept && in_last_byte) begin
      ovalid_nxt  = 1'b1;
      killer_nxt  = 1'b0;
      nosync_nxt  = 1'b0;
      obefore_nxt = '0;
      oruns_nxt   = '0;
      hvalid_nxt  = 1'b0;
      for (int i = 0; i < HDR_LEN; i++) begin
        hdr_nxt[i] = '0;
      end
      priority if (killer_hit) begin
        killer_nxt = 1'b1;
      end else if (sync_nxt == '0) begin
        nosync_nxt = 1'b1;
      end else begin
        obefore_nxt = lead_nxt;
        oruns_nxt   = runs_nxt;
        if ((idx_nxt >= HDR_IDX) && trail_nxt) begin
          hvalid_nxt = 1'b1;
          for (int i = 0; i < HDR_LEN; i++) begin
            hdr_nxt[i] = cap_nxt[i];
          end
        end
      end
    end
  end

  // control state: cleared on reset and at the end of each track
  always_ff @(posedge clk) begin
    if (!rst_n || (accept && in_last_byte)) begin
      total_r <= '0;
      sync_r  <= '0;
      lead_r  <= '0;
      runs_r  <= '0;
      inrun_r <= 1'b0;
      frs_r   <= FRS_NONE;
      idx_r   <= '0;
      trail_r <= 1'b0;
    end else begin
      total_r <= total_nxt;
      sync_r  <= sync_nxt;
      lead_r  <= lead_nxt;
      runs_r  <= runs_nxt;
      inrun_r <= inrun_nxt;
      frs_r   <= frs_nxt;
      idx_r   <= idx_nxt;
      trail_r <= trail_nxt;
    end
  end

  // captured bytes are only reported once all of them are rewritten
  always_ff @(posedge clk) begin
    for (int i = 0; i < HDR_LEN; i++) begin
      cap_r[i] <= cap_nxt[i];
      hdr_r[i] <= hdr_nxt[i];
    end
    killer_r  <= killer_nxt;
    nosync_r  <= nosync_nxt;
    obefore_r <= obefore_nxt;
    oruns_r   <= oruns_nxt;
    hvalid_r  <= hvalid_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ovalid_r <= 1'b0;
    end else begin
      ovalid_r <= ovalid_nxt;
    end
  end

  assign out_valid             = ovalid_r;
  assign out_killer_track      = killer_r;
  assign out_no_sync_found     = nosync_r;
  assign out_bytes_before_sync = obefore_r;
  assign out_sync_runs         = oruns_r;
  assign out_header_valid      = hvalid_r;
  assign out_header_byte0      = hdr_r[0];
  assign out_header_byte1      = hdr_r[1];
  assign out_header_byte2      = hdr_r[2];
  assign out_header_byte3      = hdr_r[3];
  assign out_header_byte4      = hdr_r[4];

endmodule

`default_nettype wire

/* sv/gcr_tsa_checker.sv */
// ----------------------------------------------------------------------------
// GCR track sync analyser checker
// Port-level assertions on report transactions, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module gcr_tsa_checker
  import gcr_tsa_pkg::*;
(
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               in_valid,
  input wire logic               in_ready,
  input wire logic               in_last_byte,
  input wire logic               out_valid,
  input wire logic               out_ready,
  input wire logic               out_killer_track,
  input wire logic               out_no_sync_found,
  input wire logic [FIELD_W-1:0] out_bytes_before_sync,
  input wire logic [FIELD_W-1:0] out_sync_runs,
  input wire logic               out_header_valid
);

  // a report only follows a last-byte transaction
  a_report_follows_last: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && in_ready && in_last_byte))
    else $error("report without a last-byte transaction");

  // killer report carries nothing else
  a_killer_alone: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_killer_track) |->
      (!out_no_sync_found && !out_header_valid &&
       out_bytes_before_sync == '0 && out_sync_runs == '0))
    else $error("killer report with other fields set");

  // no-sync report carries nothing else
  a_nosync_alone: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_no_sync_found) |->
      (!out_header_valid && out_bytes_before_sync == '0 && out_sync_runs == '0))
    else $error("no-sync report with other fields set");

  // a header needs at least one sync run
  a_header_needs_run: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_header_valid) |-> (out_sync_runs != '0))
    else $error("header reported with no sync run");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(out_sync_runs) && $stable(out_bytes_before_sync)))
    else $error("stalled report changed");

endmodule

bind gcr_track_sync_analyzer_top gcr_tsa_checker u_gcr_tsa_checker (
  .clk                   (clk),
  .rst_n                 (rst_n),
  .in_valid              (in_valid),
  .in_ready              (in_ready),
  .in_last_byte          (in_last_byte),
  .out_valid             (out_valid),
  .out_ready             (out_ready),
  .out_killer_track      (out_killer_track),
  .out_no_sync_found     (out_no_sync_found),
  .out_bytes_before_sync (out_bytes_before_sync),
  .out_sync_runs         (out_sync_runs),
  .out_header_valid      (out_header_valid)
);

`default_nettype wire

/* test/tb_top.sv */
// ----------------------------------------------------------------------------
// Track sync analyser testbench
// Streams directed and random tracks through the analyser with bursty input
// and a stalling receiver. Each end-of-track report is predicted from the
// accepted bytes and compared field by field with the DUT output.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
  import gcr_tsa_pkg::*;

  typedef struct {
    byte_t data;
    bit    last;
    bit    hold_off;
  } track_item_t;

  typedef struct packed {
    logic                    killer;
    logic                    no_sync;
    logic [FIELD_W-1:0]      lead;
    logic [FIELD_W-1:0]      runs;
    logic                    hdr_ok;
    logic [HDR_LEN-1:0][7:0] hdr;
  } track_report_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [7:0]         in_track_byte = '0;
  logic               in_last_byte = 1'b0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic               out_killer_track;
  logic               out_no_sync_found;
  logic [FIELD_W-1:0] out_bytes_before_sync;
  logic [FIELD_W-1:0] out_sync_runs;
  logic               out_header_valid;
  logic [7:0]         out_header_byte0;
  logic [7:0]         out_header_byte1;
  logic [7:0]         out_header_byte2;
  logic [7:0]         out_header_byte3;
  logic [7:0]         out_header_byte4;

  gcr_track_sync_analyzer_top dut (.*);

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
  end

  track_item_t   track_items[$];
  track_report_t expected_reports[$];

  int mismatches   = 0;
  int reports_seen = 0;
  int bytes_sent   = 0;
  int n_killer     = 0;
  int n_no_sync    = 0;
  int n_header     = 0;

  // predicted track state
  logic [CNT_W-1:0]        seen_total;
  logic [CNT_W-1:0]        seen_sync;
  logic [FIELD_W-1:0]      seen_lead;
  logic [FIELD_W-1:0]      seen_runs;
  logic                    in_sync_run;
  first_run_t              run_phase;
  logic [2:0]              hdr_idx;
  logic [HDR_LEN-1:0][7:0] hdr_bytes;
  logic                    tail_seen;

  task automatic clear_track();
    seen_total  = '0;
    seen_sync   = '0;
    seen_lead   = '0;
    seen_runs   = '0;
    in_sync_run = 1'b0;
    run_phase   = FRS_NONE;
    hdr_idx     = '0;
    hdr_bytes   = '0;
    tail_seen   = 1'b0;
  endtask

  task automatic track_step(input byte_t b, input logic last);
    track_report_t rep;
    if (seen_total < MAX_TRACK_BYTES) seen_total++;
    if (b == SYNC_BYTE) begin
      if (seen_sync < MAX_TRACK_BYTES) seen_sync++;
      if (!in_sync_run && seen_runs < SMALL_CAP_I) seen_runs++;
      in_sync_run = 1'b1;
      if (run_phase == FRS_NONE) run_phase = FRS_IN_FIRST;
    end else begin
      in_sync_run = 1'b0;
      if (run_phase == FRS_NONE) begin
        if (seen_lead < SMALL_CAP_I) seen_lead++;
      end else if (run_phase == FRS_IN_FIRST) begin
        run_phase = FRS_DONE;
      end
    end
    if (run_phase == FRS_DONE) begin
      if (hdr_idx < HDR_LEN) begin
        hdr_bytes[hdr_idx] = b;
        hdr_idx++;
      end else begin
        tail_seen = 1'b1;
      end
    end
    if (last) begin
      rep = '0;
      if (int'(seen_sync) * 10 > int'(seen_total) * 9) begin
        rep.killer = 1'b1;
        n_killer++;
      end else if (seen_sync == 0) begin
        rep.no_sync = 1'b1;
        n_no_sync++;
      end else begin
        rep.lead = seen_lead;
        rep.runs = seen_runs;
        if (hdr_idx >= HDR_LEN && tail_seen) begin
          rep.hdr_ok = 1'b1;
          rep.hdr    = hdr_bytes;
          n_header++;
        end
      end
      expected_reports.push_back(rep);
      clear_track();
    end
  endtask

  task automatic flag_field(input string field, input int unsigned want,
                            input int unsigned got);
    if (want != got) begin
      mismatches++;
      if (mismatches <= 10)
        $display("report %0d, %s: expected 0x%0h, got 0x%0h",
                 reports_seen, field, want, got);
    end
  endtask

  // driver
  int          burst_left = 0;
  int          gap_left   = 0;
  bit          drain_wait = 1'b0;
  track_item_t head;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (track_items.size() == 0) begin
        in_valid <= 1'b0;
      end else if (track_items[0].hold_off &&
                   !(drain_wait && expected_reports.size() == 0)) begin
        drain_wait = 1'b1;
        in_valid <= 1'b0;
      end else begin
        head = track_items.pop_front();
        drain_wait = 1'b0;
        in_valid      <= 1'b1;
        in_track_byte <= head.data;
        in_last_byte  <= head.last;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(0, 24);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end
      end
    end
  end

  // receiver stall pattern
  logic [15:0] stall_pat = 16'hFFFF;
  int          pat_age   = 0;

  always @(posedge clk) begin
    if (pat_age == 0) begin
      pat_age   = $urandom_range(16, 200);
      stall_pat = ($urandom_range(0, 2) == 0) ? 16'hFFFF : 16'($urandom);
    end else begin
      pat_age--;
      stall_pat = {stall_pat[14:0], stall_pat[15]};
    end
    out_ready <= stall_pat[0];
  end

  // monitor
  track_report_t want;

  always @(posedge clk) begin
    if (!rst_n) begin
      clear_track();
    end else begin
      if (in_valid && in_ready) begin
        bytes_sent++;
        track_step(in_track_byte, in_last_byte);
      end
      if (out_valid && out_ready) begin
        if (expected_reports.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("report %0d arrived with no track pending", reports_seen);
        end else begin
          want = expected_reports.pop_front();
          flag_field("killer_track", want.killer, out_killer_track);
          flag_field("no_sync_found", want.no_sync, out_no_sync_found);
          flag_field("bytes_before_sync", want.lead, out_bytes_before_sync);
          flag_field("sync_runs", want.runs, out_sync_runs);
          flag_field("header_valid", want.hdr_ok, out_header_valid);
          flag_field("header_byte0", want.hdr[0], out_header_byte0);
          flag_field("header_byte1", want.hdr[1], out_header_byte1);
          flag_field("header_byte2", want.hdr[2], out_header_byte2);
          flag_field("header_byte3", want.hdr[3], out_header_byte3);
          flag_field("header_byte4", want.hdr[4], out_header_byte4);
        end
        reports_seen++;
      end
    end
  end

  function automatic byte_t plain_byte();
    return byte_t'($urandom_range(0, 254));
  endfunction

  task automatic push_track(input byte_t bytes[$], input bit hold_off);
    foreach (bytes[i])
      track_items.push_back('{bytes[i], i == bytes.size() - 1, hold_off && i == 0});
  endtask

  task automatic random_track(output byte_t t[$]);
    int style;
    int n;
    int k;
    t = {};
    style = $urandom_range(0, 9);
    if (style < 6) begin
      // lead-in, sync run, header, tail with further runs
      n = $urandom_range(0, 6);
      repeat (n) t.push_back(plain_byte());
      n = $urandom_range(1, 5);
      repeat (n) t.push_back(SYNC_BYTE);
      t.push_back(plain_byte());
      repeat (HDR_LEN - 1)
        t.push_back(($urandom_range(0, 5) == 0) ? SYNC_BYTE : byte_t'($urandom));
      n = $urandom_range(1, 12);
      repeat (n) t.push_back(($urandom_range(0, 3) == 0) ? SYNC_BYTE : plain_byte());
    end else if (style == 6) begin
      // short tail after the first run
      n = $urandom_range(0, 3);
      repeat (n) t.push_back(plain_byte());
      n = $urandom_range(1, 3);
      repeat (n) t.push_back(SYNC_BYTE);
      n = $urandom_range(0, HDR_LEN);
      if (n > 0) t.push_back(plain_byte());
      repeat (n - 1) t.push_back(byte_t'($urandom));
    end else if (style == 7) begin
      n = $urandom_range(1, 20);
      repeat (n) t.push_back(($urandom_range(0, 4) < 2) ? SYNC_BYTE : plain_byte());
    end else if (style == 8) begin
      // sync share around the killer threshold
      n = $urandom_range(1, 30);
      k = (n * 9) / 10 + $urandom_range(0, 1);
      if (k > n) k = n;
      for (int i = n; i > 0; i--) begin
        if ($urandom_range(1, i) <= k) begin
          t.push_back(SYNC_BYTE);
          k--;
        end else begin
          t.push_back(plain_byte());
        end
      end
    end else begin
      n = $urandom_range(1, 15);
      repeat (n) t.push_back(plain_byte());
    end
  endtask

  initial begin : stimulus
    byte_t t[$];
    int    random_items;
    bit    first_random;

    t = {8'h00};
    push_track(t, 1'b0);
    t = {8'hFF};
    push_track(t, 1'b0);
    t = {8'h00, 8'hFF, 8'hFF, 8'h12, 8'h34, 8'hFF, 8'h56, 8'h78, 8'h9A};
    push_track(t, 1'b0);
    t = {8'hFF, 8'h01, 8'h02, 8'h03, 8'h04, 8'h05};
    push_track(t, 1'b0);
    t = {8'h7F, 8'h80, 8'hFE};
    push_track(t, 1'b0);

    random_items = 0;
    first_random = 1'b1;
    while (random_items < 830) begin
      random_track(t);
      push_track(t, first_random || $urandom_range(0, 39) == 0);
      first_random = 1'b0;
      random_items += t.size();
    end

    wait (rst_n === 1'b1);
    while (track_items.size() != 0 || in_valid) @(posedge clk);
    while (expected_reports.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);

    $display("%0d bytes in %0d track reports: %0d killer, %0d without sync, %0d with header",
             bytes_sent, reports_seen, n_killer, n_no_sync, n_header);
    if (mismatches == 0) begin
      $display("[gcr_track_sync_analyzer_top] OK");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("[gcr_track_sync_analyzer_top] ERROR");
    end
    $finish;
  end

  initial begin : watchdog
    #(8 * 1000000);
    $display("[gcr_track_sync_analyzer_top] ERROR");
    $finish;
  end

endmodule

`default_nettype wire
